// ===== rtl/core/crrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chained range remap core.
// No dependencies.
package crrm_pkg;

	localparam int STAGE_COUNT    = 8;
	localparam int SEGS_PER_STAGE = 64;
	localparam int TOTAL_SEGS     = STAGE_COUNT * SEGS_PER_STAGE;

	localparam int ADDR_W = (TOTAL_SEGS > 1) ? $clog2(TOTAL_SEGS) : 1;
	localparam int STG_W  = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
	localparam int SLOT_W = (SEGS_PER_STAGE > 1) ? $clog2(SEGS_PER_STAGE) : 1;
	localparam int CNT_W  = $clog2(STAGE_COUNT + 1);

	localparam int DATA_W = 64;
	localparam int ACT_W  = 4;
	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(7);

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_QUERY = 2'd1,
		FN_CLEAR = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	// One stored segment
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] dest;
		logic [DATA_W-1:0] src;
		logic [DATA_W-1:0] len;
	} seg_word_t;

	localparam int SEG_W = $bits(seg_word_t);

	// Read request from the walker to the segment memory
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

// ===== rtl/core/crrm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module crrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/crrm_xlate.sv =====
`timescale 1ns / 1ps
// Query walker: sweeps the segment memory stage by stage and applies
// the first covering segment of each stage. Depends on crrm_pkg.
module crrm_xlate (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [crrm_pkg::DATA_W-1:0]     start_value,
	input  logic [crrm_pkg::CNT_W-1:0]      stage_cnt,
	input  crrm_pkg::seg_word_t             rd_data,
	output crrm_pkg::rd_req_t               rd,
	output logic                            done,
	output logic [crrm_pkg::DATA_W-1:0]     result
);
	import crrm_pkg::*;

	logic              run_q;
	logic              gap_q;
	logic [STG_W-1:0]  stg_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  n_q;
	logic [DATA_W-1:0] v_q;
	logic              done_q;
	logic              fin_q;

	// data-cycle tags
	logic rv_q, rfirst_q, rlast_q;

	// evaluate stage
	logic              vld_s1, first_s1, last_s1, hit_s1;
	logic [DATA_W-1:0] diff_s1, dest_s1;

	logic              issue;
	logic              slot_end;
	logic              stg_end;
	logic [DATA_W:0]   diff;
	logic              hit;

	assign issue    = run_q && !gap_q;
	assign slot_end = int'(slot_q) == SEGS_PER_STAGE - 1;
	assign stg_end  = int'(stg_q) == int'(n_q) - 1;

	assign rd.en   = issue;
	assign rd.addr = ADDR_W'(int'(stg_q) * SEGS_PER_STAGE + int'(slot_q));

	// 65-bit subtract: carry-out clear means value >= source
	assign diff = {1'b0, v_q} - {1'b0, rd_data.src};
	assign hit  = rd_data.vld && !diff[DATA_W] && (diff[DATA_W-1:0] < rd_data.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			gap_q    <= 1'b0;
			stg_q    <= '0;
			slot_q   <= '0;
			n_q      <= '0;
			rv_q     <= 1'b0;
			rfirst_q <= 1'b0;
			rlast_q  <= 1'b0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			hit_s1   <= 1'b0;
			done_q   <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			// address sweep, with an idle gap state between stages so the
			// committed value is ready for the next stage's first compare
			if (start) begin
				run_q  <= 1'b1;
				gap_q  <= 1'b0;
				stg_q  <= '0;
				slot_q <= '0;
				n_q    <= stage_cnt;
			end else if (gap_q) begin
				gap_q <= 1'b0;
			end else if (run_q) begin
				if (slot_end) begin
					slot_q <= '0;
					if (stg_end) begin
						run_q <= 1'b0;
					end else begin
						stg_q <= stg_q + 1'b1;
						gap_q <= 1'b1;
					end
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end

			rv_q     <= issue;
			rfirst_q <= issue && (slot_q == '0);
			rlast_q  <= issue && slot_end && stg_end;

			vld_s1   <= rv_q;
			first_s1 <= rfirst_q;
			last_s1  <= rlast_q;
			hit_s1   <= rv_q && hit;

			// first hit in a stage wins, later hits are dropped
			if (vld_s1) begin
				done_q <= first_s1 ? hit_s1 : (done_q || hit_s1);
			end
			fin_q <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff[DATA_W-1:0];
		dest_s1 <= rd_data.dest;
		if (start) begin
			v_q <= start_value;
		end else if (vld_s1 && hit_s1 && (first_s1 || !done_q)) begin
			v_q <= diff_s1 + dest_s1;
		end
	end

	assign done   = fin_q;
	assign result = v_q;

endmodule

// ===== rtl/core/chained_range_remap_min_core.sv =====
`timescale 1ns / 1ps
// Chained range remap with running minimum: top level.
// Write, clear and no-op beats go straight to the response state; a query
//   walks n = min(active_stages, STAGE_COUNT) stages of SEGS_PER_STAGE segments,
//   and goes straight to the response state when n is 0.
// Throughput: one beat at a time; the sweep reads a segment per cycle within a stage.
// Reset: a clearing pass over all TOTAL_SEGS (512) segments wipes the valid bits
//   before the first input beat is taken; running minimum resets to all ones.
// Depends on crrm_pkg, crrm_ram, crrm_xlate.
module chained_range_remap_min_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [crrm_pkg::ACT_W-1:0]      cfg_wr_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [2:0]                      stage_sel,
	input  logic [5:0]                      slot_sel,
	input  logic [63:0]                     seg_dest_in,
	input  logic [63:0]                     seg_source_in,
	input  logic [63:0]                     seg_length_in,
	input  logic                            seg_enable,
	input  logic [63:0]                     query_value,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [63:0]                     mapped_value,
	output logic [63:0]                     lowest_seen,
	output logic                            was_query
);
	import crrm_pkg::*;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ACT_W-1:0]  active_stages_q;
	logic [DATA_W-1:0] min_q;
	logic [DATA_W-1:0] res_val_q;
	logic              res_query_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] mapped_q;
	logic [DATA_W-1:0] lowest_q;
	logic              was_query_q;

	logic              accept;
	logic              in_range;
	logic [CNT_W-1:0]  n_stages;
	logic              xl_start;
	logic              out_free;
	logic [DATA_W-1:0] new_min;

	// segment memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	seg_word_t         ram_wdata;
	seg_word_t         ram_rdata;
	rd_req_t           xl_rd;
	logic              xl_done;
	logic [DATA_W-1:0] xl_result;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign in_range = (int'(stage_sel) < STAGE_COUNT) && (int'(slot_sel) < SEGS_PER_STAGE);

	// active stage count saturates at the number of stages built
	always_comb begin
		if (int'(active_stages_q) > STAGE_COUNT) begin
			n_stages = CNT_W'(STAGE_COUNT);
		end else begin
			n_stages = CNT_W'(active_stages_q);
		end
	end

	assign xl_start = accept && (func_t'(func) == FN_QUERY) && (n_stages != '0);

	// Memory writes: clearing sweep after reset, otherwise a segment-write beat.
	// Data words of the sweep are don't-care; only the valid bit matters.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(int'(stage_sel) * SEGS_PER_STAGE + int'(slot_sel));
		ram_wdata = '{vld: seg_enable, dest: seg_dest_in, src: seg_source_in,
			len: seg_length_in};
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (accept && (func_t'(func) == FN_WRITE) && in_range) begin
			ram_we = 1'b1;
		end
	end

	crrm_ram #(
		.WIDTH(SEG_W),
		.DEPTH(TOTAL_SEGS)
	) u_seg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (xl_rd.en),
		.raddr(xl_rd.addr),
		.rdata(ram_rdata)
	);

	crrm_xlate u_xlate (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (xl_start),
		.start_value(query_value),
		.stage_cnt  (n_stages),
		.rd_data    (ram_rdata),
		.rd         (xl_rd),
		.done       (xl_done),
		.result     (xl_result)
	);

	// min folds in only for query results
	assign new_min = (res_query_q && (res_val_q < min_q)) ? res_val_q : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLR;
			clr_addr_q      <= '0;
			active_stages_q <= ACT_RESET;
			min_q           <= '1;
			res_query_q     <= 1'b0;
			out_valid_q     <= 1'b0;
			mapped_q        <= '0;
			lowest_q        <= '1;
			was_query_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				active_stages_q <= cfg_wr_data;
			end
			// in ST_RESP the result register is reloaded below instead
			if (out_valid_q && out_ready && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (int'(clr_addr_q) == TOTAL_SEGS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_query_q <= (func_t'(func) == FN_QUERY);
						case (func_t'(func))
							FN_QUERY: begin
								state_q <= xl_start ? ST_WALK : ST_RESP;
							end
							FN_CLEAR: begin
								min_q   <= '1;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (xl_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						min_q       <= new_min;
						out_valid_q <= 1'b1;
						mapped_q    <= res_val_q;
						lowest_q    <= new_min;
						was_query_q <= res_query_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// beat value held between accept and response
	always_ff @(posedge clk) begin
		if (accept) begin
			res_val_q <= (func_t'(func) == FN_QUERY) ? query_value : '0;
		end else if ((state_q == ST_WALK) && xl_done) begin
			res_val_q <= xl_result;
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_value = mapped_q;
	assign lowest_seen  = lowest_q;
	assign was_query    = was_query_q;

	// walker never reads while the memory is being written
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && xl_rd.en))
		else $error("segment read during write");

	// walker finishes only while a query is in flight
	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		xl_done |-> (state_q == ST_WALK))
		else $error("walker done outside walk");

	// a query result never sits below the reported minimum
	a_min_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && was_query_q |-> (lowest_q <= mapped_q))
		else $error("minimum above query result");

	// non-query results carry a zero value
	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && !was_query_q |-> (mapped_q == '0))
		else $error("non-query result not zero");

endmodule
